>>> sv/nsr_pkg.sv
// Shared constants and controller/datapath handshake types for the Newton square root block.
package nsr_pkg;

  localparam int RADICAND_W        = 32;
  localparam int ROOT_W            = 25;
  localparam int STEPS_W           = 6;
  localparam int LIMIT_W           = 6;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);
  localparam logic [ROOT_W-1:0]  ROOT_MAX    = '1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture radicand, reset estimate and step count
    logic div_start;  // launch quotient scaled / est
    logic update;     // est <= candidate, steps++
    logic publish;    // move result into output register
  } nsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_zero;    // radicand on the input channel is zero
    logic div_done;   // quotient ready
    logic converged;  // candidate equals current estimate after first step
    logic limit_hit;  // step about to be taken reaches the limit
    logic out_busy;   // output register holds an untaken result
  } nsr_status_t;

endpackage

>>> sv/nsr_if.sv
// Channel interfaces: radicand input, result output, iteration limit write.
interface nsr_in_if;
  logic                              valid;
  logic                              ready;
  logic [nsr_pkg::RADICAND_W-1:0]    radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
  logic                           valid;
  logic                           ready;
  logic [nsr_pkg::ROOT_W-1:0]     root;
  logic [nsr_pkg::STEPS_W-1:0]    steps_taken;
  logic                           bad_input;

  modport source (output valid, output root, output steps_taken, output bad_input,
                  input ready);
  modport sink   (input valid, input root, input steps_taken, input bad_input,
                  output ready);
endinterface

interface nsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nsr_pkg::LIMIT_W-1:0]    iteration_limit;

  modport source (output valid, output iteration_limit, input ready);
  modport sink   (input valid, input iteration_limit, output ready);
endinterface

>>> sv/nsr_div.sv
// Restoring divider, one quotient bit per cycle.
module nsr_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dq;
  logic [W-1:0]     dvsr;
  logic [W:0]       rem_shift;
  logic [W:0]       rem_diff;
  logic             fits;

  assign rem_shift = {rem, dq[W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvsr};
  assign fits      = (rem_shift >= {1'b0, dvsr});
  assign quotient  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dq   <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_diff[W-1:0] : rem_shift[W-1:0];
      dq  <= {dq[W-2:0], fits};
    end
  end

endmodule

>>> sv/nsr_datapath.sv
// Datapath: estimate, step count, limit register, divider and output register.
module nsr_datapath #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nsr_pkg::nsr_cmd_t                cmd,
  output nsr_pkg::nsr_status_t             status,
  input  logic [nsr_pkg::RADICAND_W-1:0]   radicand,
  input  logic                             cfg_wr,
  input  logic [nsr_pkg::LIMIT_W-1:0]      cfg_limit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nsr_pkg::ROOT_W-1:0]       root,
  output logic [nsr_pkg::STEPS_W-1:0]      steps_taken,
  output logic                             bad_input
);

  localparam int W = nsr_pkg::RADICAND_W + FRAC_BITS;

  logic [W-1:0]                  scaled;
  logic [W-1:0]                  est;
  logic [W-1:0]                  quot;
  logic [W-1:0]                  quot_eff;
  logic [W:0]                    sum;
  logic [W-1:0]                  cand;
  logic [nsr_pkg::STEPS_W-1:0]   steps;
  logic [nsr_pkg::STEPS_W:0]     steps_inc;
  logic [nsr_pkg::LIMIT_W-1:0]   limit;
  logic                          bad;
  logic                          div_done;
  logic [nsr_pkg::ROOT_W-1:0]    root_sat;

  nsr_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (scaled),
    .divisor  (est),
    .quotient (quot),
    .done     (div_done)
  );

  // divide by zero yields zero quotient
  assign quot_eff  = (est == '0) ? '0 : quot;
  assign sum       = {1'b0, est} + {1'b0, quot_eff};
  assign cand      = sum[W:1];
  assign steps_inc = {1'b0, steps} + 1'b1;
  assign root_sat  = (est > W'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                   : est[nsr_pkg::ROOT_W-1:0];

  always_comb begin
    status.in_zero   = (radicand == '0);
    status.div_done  = div_done;
    status.converged = (steps != '0) && (cand == est);
    status.limit_hit = (steps_inc >= {1'b0, limit});
    status.out_busy  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scaled <= W'(radicand) << FRAC_BITS;
      est    <= W'(1) << FRAC_BITS;
      steps  <= '0;
      bad    <= (radicand == '0);
    end else if (cmd.update) begin
      est   <= cand;
      steps <= steps_inc[nsr_pkg::STEPS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= nsr_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit <= cfg_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      root        <= bad ? '0 : root_sat;
      steps_taken <= bad ? '0 : steps;
      bad_input   <= bad;
    end
  end

endmodule

>>> sv/nsr_ctrl.sv
// Controller: sequences load, divide, evaluate and publish for one radicand.
module nsr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nsr_pkg::nsr_status_t  status,
  output nsr_pkg::nsr_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_START   = 5'b00010,
    S_DIV     = 5'b00100,
    S_EVAL    = 5'b01000,
    S_PUBLISH = 5'b10000
  } nsr_state_t;

  nsr_state_t state;
  nsr_state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_zero ? S_PUBLISH : S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.converged) begin
          state_next = S_PUBLISH;
        end else begin
          cmd.update = 1'b1;
          state_next = status.limit_hit ? S_PUBLISH : S_START;
        end
      end
      S_PUBLISH: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/newton_square_root.sv
// Top level: Newton-Raphson square root of an unsigned fixed-point radicand.
// Usage:
//   radicand_ch : one transaction carries a radicand, unsigned, FRAC_BITS fraction bits.
//   result_ch   : one transaction per radicand: root (saturated to 25 bits),
//                 steps_taken and bad_input (radicand was zero, root and steps zero).
//   cfg         : writes iteration_limit; always ready, take effect from the next
//                 radicand. Write only while no radicand is in flight.
// Timing: the estimate starts at 1.0; each Newton step runs one divide of width
//   W = 32 + FRAC_BITS (48 at Q16.16) on the bit-serial divider, which yields one
//   quotient bit per cycle. A result takes as many divides as steps_taken when
//   the limit stops it, one divide more when the estimate settles; a zero radicand
//   skips the divider. Up to 20 steps at the reset limit.
// Throughput: one radicand at a time; radicand_ch.ready is high only when the
//   engine is idle, which may be while an earlier result still sits in the
//   output register.
// Reset (rst, synchronous): engine idle, output register empty,
//   iteration_limit back to 20.
// Receiver stall: the result holds in the output register; the next radicand
//   is still taken and worked on, and its result waits for the register.
module newton_square_root #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  nsr_in_if.sink        radicand_ch,
  nsr_out_if.source     result_ch,
  nsr_cfg_if.sink       cfg
);

  nsr_pkg::nsr_cmd_t    cmd;
  nsr_pkg::nsr_status_t status;

  // limit register is a plain flop, any cycle can take a write
  assign cfg.ready = 1'b1;

  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (radicand_ch.valid),
    .in_ready (radicand_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nsr_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .radicand    (radicand_ch.radicand),
    .cfg_wr      (cfg.valid),
    .cfg_limit   (cfg.iteration_limit),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .root        (result_ch.root),
    .steps_taken (result_ch.steps_taken),
    .bad_input   (result_ch.bad_input)
  );

endmodule

>>> sv/nsr_checker.sv
// Port-level checker for the square root block, bound to the top level.
module nsr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [nsr_pkg::ROOT_W-1:0]     root,
  input logic [nsr_pkg::STEPS_W-1:0]    steps_taken,
  input logic                           bad_input
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root) && $stable(steps_taken)
                                && $stable(bad_input))
    else $error("result changed while stalled");

  // engine is busy in the cycle after taking a radicand
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("radicand accepted on consecutive cycles");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> root == '0 && steps_taken == '0)
    else $error("zero radicand result carries data");

  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_input |-> steps_taken != '0)
    else $error("valid radicand result reports no steps");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (radicand_ch.valid),
  .in_ready    (radicand_ch.ready),
  .out_valid   (result_ch.valid),
  .out_ready   (result_ch.ready),
  .root        (result_ch.root),
  .steps_taken (result_ch.steps_taken),
  .bad_input   (result_ch.bad_input)
);
